// ----- rtl/ifdd_pkg.sv -----
// ----------------------------------------------------------------------------
// ifdd_pkg
// shared types and constants of the byte-stuffed information frame receiver
// ----------------------------------------------------------------------------
package ifdd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 12;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 12'd2048;

    localparam logic [BYTE_W-1:0] FLAG_BYTE    = 8'h7e;
    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h7d;
    localparam logic [BYTE_W-1:0] FLAG_SUB     = 8'h5e;
    localparam logic [BYTE_W-1:0] ESC_SUB      = 8'h5d;
    localparam logic [BYTE_W-1:0] ADDR_RESET   = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_SEQ0    = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_SEQ1    = 8'b0100_0000;
    localparam logic [BYTE_W-1:0] RR_AFTER0    = 8'b1000_0101;
    localparam logic [BYTE_W-1:0] RR_AFTER1    = 8'b0000_0101;
    localparam logic [BYTE_W-1:0] REJ_WHILE0   = 8'b1000_0001;
    localparam logic [BYTE_W-1:0] REJ_WHILE1   = 8'b0000_0001;

    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_FLAG = 5'b00010,
        PH_ADDR = 5'b00100,
        PH_CTRL = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
        logic [BYTE_W-1:0] reply_control;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

endpackage

// ----- rtl/info_frame_deframer_destuffer.sv -----
// a byte is registered in the input register; its result is registered in the result register
// one byte per cycle unless a stalled consumer holds the result register full
// a byte that gives no result still passes through the input register
// reset: synchronous active-low; hunts for an opening flag, expects sequence 0,
//   station address 0x03, output empty
// ----------------------------------------------------------------------------
// info_frame_deframer_destuffer
// byte-stuffed information frame receiver with header check and verdict
// ----------------------------------------------------------------------------
module info_frame_deframer_destuffer
    import ifdd_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ifdd_pkg::BYTE_W-1:0]      i_cfg_data,   // station_address
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ifdd_pkg::BYTE_W-1:0]      i_s_tdata,    // rx_byte
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ifdd_pkg::OUT_TDATA_W-1:0] o_m_tdata,    // data_byte, reply_control,
                                                           // payload_length, zero pad
    output logic                             o_m_tlast,    // frame_end
    output logic [ifdd_pkg::KIND_W-1:0]      o_m_tuser     // result_kind
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              out_ready;
    logic              advance;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && out_ready;
    assign o_s_tready  = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    ifdd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_addr  (i_cfg_data),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ifdd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_m_tvalid),
        .i_take  (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {4'd0, out_res.payload_length, out_res.reply_control, out_res.data_byte};
    assign o_m_tlast = out_res.frame_end;
    assign o_m_tuser = out_res.result_kind;

endmodule

// ----- rtl/ifdd_core.sv -----
// ----------------------------------------------------------------------------
// ifdd_core
// framing state, header check, destuffing, hold-back and frame verdict
// ----------------------------------------------------------------------------
module ifdd_core
    import ifdd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr,
    input  logic [ifdd_pkg::BYTE_W-1:0] i_cfg_addr,
    input  logic                    i_step,
    input  logic [ifdd_pkg::BYTE_W-1:0] i_byte,
    output logic                    o_res_valid,
    output ifdd_pkg::t_result       o_res
);

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_addr;
    logic                r_esc, n_esc;
    logic [BYTE_W-1:0]   r_held, n_held;
    logic                r_held_vld, n_held_vld;
    logic [BYTE_W-1:0]   r_xor, n_xor;
    logic                r_seq, n_seq;
    logic [LEN_W-1:0]    r_count, n_count;
    logic                r_bad, n_bad;

    logic [BYTE_W-1:0]   ctrl;
    logic [BYTE_W-1:0]   d;
    logic                got;
    logic                ok;

    always_comb begin
        n_phase     = r_phase;
        n_esc       = r_esc;
        n_held      = r_held;
        n_held_vld  = r_held_vld;
        n_xor       = r_xor;
        n_seq       = r_seq;
        n_count     = r_count;
        n_bad       = r_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        ctrl        = r_seq ? CTRL_SEQ1 : CTRL_SEQ0;
        d           = i_byte;
        got         = 1'b0;
        ok          = !r_bad && !r_esc && r_held_vld && (r_count != '0) && (r_held == r_xor);
        if (i_step) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == FLAG_BYTE) n_phase = PH_FLAG;
                end
                PH_FLAG: begin
                    if (i_byte == r_addr) n_phase = PH_ADDR;
                    else n_phase = (i_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
                PH_ADDR: begin
                    if (i_byte == ctrl) n_phase = PH_CTRL;
                    else n_phase = (i_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
                PH_CTRL: begin
                    if (i_byte == (r_addr ^ ctrl)) begin
                        n_phase    = PH_DATA;
                        n_esc      = 1'b0;
                        n_held     = '0;
                        n_held_vld = 1'b0;
                        n_xor      = '0;
                        n_count    = '0;
                        n_bad      = 1'b0;
                    end else begin
                        n_phase = (i_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (i_byte == FLAG_BYTE) begin
                        n_phase                  = PH_HUNT;
                        n_esc                    = 1'b0;
                        o_res_valid              = 1'b1;
                        o_res.frame_end          = 1'b1;
                        o_res.payload_length     = r_count;
                        if (ok) begin
                            o_res.result_kind   = KIND_ACCEPT;
                            o_res.reply_control = r_seq ? RR_AFTER1 : RR_AFTER0;
                            n_seq               = !r_seq;
                        end else begin
                            o_res.result_kind   = KIND_REJECT;
                            o_res.reply_control = r_seq ? REJ_WHILE1 : REJ_WHILE0;
                        end
                    end else if (!r_bad) begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                            if (i_byte == FLAG_SUB) begin
                                d   = FLAG_BYTE;
                                got = 1'b1;
                            end else if (i_byte == ESC_SUB) begin
                                d   = ESC_BYTE;
                                got = 1'b1;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end else if (i_byte == ESC_BYTE) begin
                            n_esc = 1'b1;
                        end else begin
                            got = 1'b1;
                        end
                        if (got) begin
                            if (r_held_vld) begin
                                if (r_count >= MAX_PAYLOAD) begin
                                    n_bad = 1'b1;
                                end else begin
                                    n_held               = d;
                                    n_xor                = r_xor ^ r_held;
                                    n_count              = r_count + 12'd1;
                                    o_res_valid          = 1'b1;
                                    o_res.result_kind    = KIND_DATA;
                                    o_res.data_byte      = r_held;
                                    o_res.payload_length = r_count + 12'd1;
                                end
                            end else begin
                                n_held     = d;
                                n_held_vld = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_addr     <= ADDR_RESET;
            r_esc      <= 1'b0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_xor      <= '0;
            r_seq      <= 1'b0;
            r_count    <= '0;
            r_bad      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_esc      <= n_esc;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_xor      <= n_xor;
            r_seq      <= n_seq;
            r_count    <= n_count;
            r_bad      <= n_bad;
            if (i_cfg_wr) begin
                r_addr <= i_cfg_addr;
            end
        end
    end

endmodule

// ----- rtl/ifdd_out.sv -----
// ----------------------------------------------------------------------------
// ifdd_out
// result register with stream handshake toward the consumer
// ----------------------------------------------------------------------------
module ifdd_out
    import ifdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ifdd_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_take,
    output ifdd_pkg::t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- dv/ifdd_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifdd_frame_checker
// watches the byte, config and result channels of the frame receiver, keeps
// its own deframing state and compares every result transfer field by field
// ----------------------------------------------------------------------------
module ifdd_frame_checker
    import ifdd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [BYTE_W-1:0]      i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tlast,
    input  logic [KIND_W-1:0]      i_m_tuser,
    output int                     o_mismatches,
    output int                     o_due,
    output logic                   o_exp_seq
);

    t_phase            ph;
    logic              esc_pend;
    logic [BYTE_W-1:0] held;
    logic              held_ok;
    logic [BYTE_W-1:0] run_xor;
    logic              seq;
    logic [LEN_W-1:0]  count;
    logic              bad;
    logic [BYTE_W-1:0] station;

    t_result due_results[$];

    initial begin
        o_mismatches = 0;
        o_due = 0;
    end

    assign o_exp_seq = seq;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (o_mismatches < 40) begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        end
        o_mismatches++;
    endtask

    // advances the receive state by one line byte, returns 1 when a result is due
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] d;
        logic              ok;
        r = '0;
        ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
        case (ph)
            PH_HUNT: begin
                if (b == FLAG_BYTE) ph = PH_FLAG;
                return 0;
            end
            PH_FLAG: begin
                if (b == station) ph = PH_ADDR;
                else ph = (b == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                return 0;
            end
            PH_ADDR: begin
                if (b == ctrl) ph = PH_CTRL;
                else ph = (b == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                return 0;
            end
            PH_CTRL: begin
                if (b == (station ^ ctrl)) begin
                    ph = PH_DATA;
                    esc_pend = 1'b0;
                    held = '0;
                    held_ok = 1'b0;
                    run_xor = '0;
                    count = '0;
                    bad = 1'b0;
                end else begin
                    ph = (b == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
                return 0;
            end
            default: ;
        endcase

        // closing flag gives the verdict
        if (b == FLAG_BYTE) begin
            ok = !bad && !esc_pend && held_ok && count != '0 && held == run_xor;
            ph = PH_HUNT;
            esc_pend = 1'b0;
            r.frame_end = 1'b1;
            r.payload_length = count;
            if (ok) begin
                r.result_kind = KIND_ACCEPT;
                r.reply_control = seq ? RR_AFTER1 : RR_AFTER0;
                seq = ~seq;
            end else begin
                r.result_kind = KIND_REJECT;
                r.reply_control = seq ? REJ_WHILE1 : REJ_WHILE0;
            end
            return 1;
        end
        if (bad) return 0;

        if (esc_pend) begin
            esc_pend = 1'b0;
            if (b == FLAG_SUB) d = FLAG_BYTE;
            else if (b == ESC_SUB) d = ESC_BYTE;
            else begin
                bad = 1'b1;
                return 0;
            end
        end else if (b == ESC_BYTE) begin
            esc_pend = 1'b1;
            return 0;
        end else begin
            d = b;
        end

        // one byte held back so that the last one is the check byte
        if (!held_ok) begin
            held = d;
            held_ok = 1'b1;
            return 0;
        end
        if (count >= MAX_PAYLOAD) begin
            bad = 1'b1;
            return 0;
        end
        r.result_kind = KIND_DATA;
        r.data_byte = held;
        r.payload_length = count + 1'b1;
        run_xor ^= held;
        count = count + 1'b1;
        held = d;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            ph = PH_HUNT;
            esc_pend = 1'b0;
            held = '0;
            held_ok = 1'b0;
            run_xor = '0;
            seq = 1'b0;
            count = '0;
            bad = 1'b0;
            station = ADDR_RESET;
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected result kind", 32'(i_m_tuser), '0);
                end else begin
                    want = due_results.pop_front();
                    if (i_m_tuser !== want.result_kind)
                        flag_mismatch("result_kind", 32'(i_m_tuser),
                                      32'(want.result_kind));
                    if (i_m_tdata[7:0] !== want.data_byte)
                        flag_mismatch("data_byte", 32'(i_m_tdata[7:0]),
                                      32'(want.data_byte));
                    if (i_m_tlast !== want.frame_end)
                        flag_mismatch("frame_end", 32'(i_m_tlast), 32'(want.frame_end));
                    if (i_m_tdata[15:8] !== want.reply_control)
                        flag_mismatch("reply_control", 32'(i_m_tdata[15:8]),
                                      32'(want.reply_control));
                    if (i_m_tdata[27:16] !== want.payload_length)
                        flag_mismatch("payload_length", 32'(i_m_tdata[27:16]),
                                      32'(want.payload_length));
                    if (i_m_tdata[31:28] !== 4'h0)
                        flag_mismatch("tdata pad", 32'(i_m_tdata[31:28]), '0);
                end
            end
            if (i_cfg_valid && i_cfg_ready) station = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (deframe_byte(i_s_tdata, fresh)) due_results.push_back(fresh);
            end
        end
        o_due = due_results.size();
    end

endmodule

// ----- dv/tb_info_frame_deframer_destuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_info_frame_deframer_destuffer
// sends good and damaged stuffed frames under several station addresses with
// bursty input and a stalling result side; the checker judges every result
// ----------------------------------------------------------------------------
module tb_info_frame_deframer_destuffer;
    import ifdd_pkg::*;

    typedef enum int {
        F_NONE,
        F_ADDR,
        F_SEQ,
        F_BCC1,
        F_BCC2,
        F_BAD_ESC,
        F_ESC_FLAG,
        F_EMPTY,
        F_FLAGS
    } t_fault;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [BYTE_W-1:0]      i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic [KIND_W-1:0]      o_m_tuser;

    int   mismatches;
    int   due;
    logic exp_seq;

    logic [BYTE_W-1:0] line_bytes[$];
    logic [BYTE_W-1:0] forced_payload[$];
    logic [BYTE_W-1:0] cur_station = ADDR_RESET;
    int   burst_left = 0;
    int   items_sent = 0;
    bit   hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    info_frame_deframer_destuffer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    ifdd_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .o_mismatches (mismatches),
        .o_due        (due),
        .o_exp_seq    (exp_seq)
    );

    // result side stall pattern, with one long hold-off on request
    initial begin
        int hold_cnt;
        int win;
        int mode;
        int tick;
        bit hold_done;
        hold_cnt = 0;
        win = 0;
        mode = 0;
        tick = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_cnt != 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_cnt = 400;
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
            end else begin
                if (win == 0) begin
                    mode = $urandom_range(0, 3);
                    win = $urandom_range(16, 96);
                end
                win--;
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    2: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic send_line();
        while (line_bytes.size() != 0) send_byte(line_bytes.pop_front());
    endtask

    // called right after a transfer; waits until nothing is due and the pipe is empty
    task automatic settle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_station(input logic [BYTE_W-1:0] a);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_station = a;
    endtask

    function automatic void push_stuffed(input logic [BYTE_W-1:0] v);
        if (v == FLAG_BYTE) begin
            line_bytes.push_back(ESC_BYTE);
            line_bytes.push_back(FLAG_SUB);
        end else if (v == ESC_BYTE) begin
            line_bytes.push_back(ESC_BYTE);
            line_bytes.push_back(ESC_SUB);
        end else begin
            line_bytes.push_back(v);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 7))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_bad_escape();
        logic [BYTE_W-1:0] v;
        do v = 8'($urandom_range(0, 255)); while (v inside {FLAG_SUB, ESC_SUB, FLAG_BYTE});
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(v);
    endfunction

    task automatic send_frame(input t_fault f, input int n);
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] bcc1;
        logic [BYTE_W-1:0] bcc2;
        logic [BYTE_W-1:0] v;
        int bad_at;
        if (forced_payload.size() != 0) n = forced_payload.size();
        if (f == F_EMPTY) n = 0;
        send_byte(FLAG_BYTE);
        if (f == F_FLAGS) repeat ($urandom_range(1, 3)) send_byte(FLAG_BYTE);
        // the sequence is read only after the opening flag went out
        addr = cur_station;
        ctrl = exp_seq ? CTRL_SEQ1 : CTRL_SEQ0;
        if (f == F_ADDR) addr ^= 8'($urandom_range(1, 255));
        if (f == F_SEQ) ctrl ^= CTRL_SEQ1;
        bcc1 = addr ^ ctrl;
        if (f == F_BCC1) bcc1 ^= 8'($urandom_range(1, 255));
        line_bytes.push_back(addr);
        line_bytes.push_back(ctrl);
        line_bytes.push_back(bcc1);
        bcc2 = '0;
        bad_at = (f == F_BAD_ESC) ? $urandom_range(0, n) : -1;
        for (int k = 0; k < n; k++) begin
            if (k == bad_at) push_bad_escape();
            v = (forced_payload.size() != 0) ? forced_payload.pop_front() : payload_byte();
            bcc2 ^= v;
            push_stuffed(v);
        end
        if (bad_at == n) push_bad_escape();
        if (f == F_BCC2) bcc2 ^= 8'($urandom_range(1, 255));
        if (f != F_EMPTY) push_stuffed(bcc2);
        if (f == F_ESC_FLAG) line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(FLAG_BYTE);
        send_line();
    endtask

    task automatic send_noise(input int n);
        repeat (n) begin
            line_bytes.push_back(($urandom_range(0, 3) == 0) ? FLAG_BYTE
                                                             : 8'($urandom_range(0, 255)));
        end
        send_line();
    endtask

    task automatic send_random_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        if (pick < 60) send_frame(F_NONE, n);
        else if (pick < 64) send_frame(F_FLAGS, n);
        else if (pick < 68) send_frame(F_ADDR, n);
        else if (pick < 72) send_frame(F_SEQ, n);
        else if (pick < 76) send_frame(F_BCC1, n);
        else if (pick < 82) send_frame(F_BCC2, n);
        else if (pick < 87) send_frame(F_BAD_ESC, n);
        else if (pick < 90) send_frame(F_ESC_FLAG, n);
        else if (pick < 93) send_frame(F_EMPTY, 0);
        else if (pick < 95) send_frame(F_NONE, 0);
        else send_noise($urandom_range(1, 8));
    endtask

    initial begin
        logic [BYTE_W-1:0] stations[6];
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset address, both sequences, stuffing, each reject path but the overlong frame
        forced_payload = '{8'h00};
        send_frame(F_NONE, 1);
        forced_payload = '{FLAG_BYTE, ESC_BYTE, 8'hff};
        send_frame(F_NONE, 3);
        send_frame(F_EMPTY, 0);
        send_frame(F_NONE, 0);
        send_frame(F_BCC2, 2);
        send_frame(F_BAD_ESC, 2);
        send_frame(F_ESC_FLAG, 2);
        send_frame(F_SEQ, 2);
        send_frame(F_ADDR, 2);
        send_frame(F_BCC1, 2);
        send_frame(F_FLAGS, 2);
        // header miss on a flag falls back to flag-seen
        line_bytes = '{FLAG_BYTE, cur_station, FLAG_BYTE};
        send_line();
        line_bytes = '{cur_station, exp_seq ? CTRL_SEQ1 : CTRL_SEQ0,
                       cur_station ^ (exp_seq ? CTRL_SEQ1 : CTRL_SEQ0), 8'h11, 8'h11,
                       FLAG_BYTE};
        send_line();
        set_station(8'h00);
        send_frame(F_NONE, 2);
        set_station(8'hff);
        send_frame(F_NONE, 2);
        set_station(FLAG_BYTE);
        send_frame(F_NONE, 2);
        send_frame(F_NONE, 3);

        // random: several address settings, one overlong frame, one long stall
        stations = '{ADDR_RESET, 8'h00, ESC_BYTE, 8'hff, 8'h00, 8'h00};
        stations[1] = 8'($urandom_range(0, 255));
        stations[5] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 6; p++) begin
            set_station(stations[p]);
            if (p == 2) send_frame(F_NONE, int'(MAX_PAYLOAD) + 1);
            while (items_sent < 100 + (p + 1) * 270 + ((p >= 2) ? 2060 : 0)) begin
                if (p == 1 && items_sent > 500) hold_req = 1'b1;
                send_random_frame();
            end
        end

        i_s_tvalid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (due != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ifdd_pkg.sv
rtl/ifdd_core.sv
rtl/ifdd_out.sv
rtl/info_frame_deframer_destuffer.sv
dv/ifdd_frame_checker.sv
dv/tb_info_frame_deframer_destuffer.sv
